### rtl/core/ipv6tlv_pkg.sv
// ----------------------------------------------------------------------------
// ipv6tlv_pkg
// Types and constants shared by the IPv6 extension header TLV option parser.
// ----------------------------------------------------------------------------
package ipv6tlv_pkg;

    // One byte of an extension header with its per-header context.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        end_of_data;
        logic        hop_by_hop;
        logic [15:0] header_offset;
        logic        dest_multicast;
        logic        payload_len_zero;
        logic [31:0] packet_length;
    } t_in_item;

    // The verdict for one header.
    typedef struct packed {
        logic [1:0]  verdict;
        logic        problem_code;
        logic [16:0] problem_pointer;
        logic        router_alert_present;
        logic [16:0] router_alert_offset;
        logic        jumbo_present;
        logic [31:0] jumbo_length;
        logic        trim_needed;
        logic [11:0] header_bytes;
    } t_out_item;

    // Verdict codes.
    localparam logic [1:0] V_ACCEPT  = 2'd0;
    localparam logic [1:0] V_DROP    = 2'd1;
    localparam logic [1:0] V_PROBLEM = 2'd2;

    // Parameter problem codes.
    localparam logic PC_FIELD  = 1'b0;
    localparam logic PC_OPTION = 1'b1;

    // Option types with special handling.
    localparam logic [7:0] OPT_PAD1  = 8'h00;
    localparam logic [7:0] OPT_PADN  = 8'h01;
    localparam logic [7:0] OPT_RA    = 8'h05;
    localparam logic [7:0] OPT_JUMBO = 8'hC2;

    // Unknown option actions, from the top two type bits.
    localparam logic [1:0] ACT_SKIP          = 2'd0;
    localparam logic [1:0] ACT_DROP          = 2'd1;
    localparam logic [1:0] ACT_PROBLEM       = 2'd2;
    localparam logic [1:0] ACT_PROBLEM_UCAST = 2'd3;

    // Fixed option lengths and the jumbo alignment.
    localparam logic [7:0]  RA_LEN      = 8'd2;
    localparam logic [7:0]  JUMBO_LEN   = 8'd4;
    localparam logic [1:0]  JUMBO_ALIGN = 2'd2;
    localparam logic [32:0] BASE_HDR    = 33'd40;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HLEN = 3'd1,
        PH_TYPE = 3'd2,
        PH_LEN  = 3'd3,
        PH_BODY = 3'd4,
        PH_SKIP = 3'd5
    } t_phase;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        t_phase      phase;
        logic [11:0] header_total;
        logic [11:0] byte_position;
        logic [11:0] option_start;
        logic [7:0]  option_type;
        logic [7:0]  option_length;
        logic [31:0] jumbo_acc;
        logic [15:0] hdr_offset;
        logic        hop;
        logic        mcast;
        logic        plz;
        logic [2:0]  found;
        logic [16:0] alert_offset;
        logic [1:0]  err_verdict;
        logic        err_code;
        logic [16:0] err_pointer;
    } t_parse_state;

endpackage

### rtl/core/ipv6tlv_step.sv
// ----------------------------------------------------------------------------
// ipv6tlv_step
// Per-byte parse logic: from the current state and one header byte it forms
// the next state and, when the header is finished, the verdict.
// ----------------------------------------------------------------------------
module ipv6tlv_step (
    input  ipv6tlv_pkg::t_parse_state i_state,
    input  ipv6tlv_pkg::t_in_item     i_item,
    output ipv6tlv_pkg::t_parse_state o_next_state,
    output logic                      o_emit,
    output ipv6tlv_pkg::t_out_item    o_result
);
    import ipv6tlv_pkg::*;

    t_parse_state n_st;
    logic [11:0]  w_pos;
    logic [16:0]  w_optoff;
    logic [11:0]  w_remaining;
    logic [7:0]   w_len_dec;
    logic [31:0]  w_jacc;
    logic [32:0]  w_jsum;
    logic [32:0]  w_plen;
    logic         w_is_jumbo;
    logic         w_last;
    logic         w_emit;
    logic [1:0]   w_emit_v;
    logic         w_fail;
    logic [1:0]   w_fail_v;
    logic         w_fail_code;
    logic [16:0]  w_fail_ptr;
    logic         w_acc;
    logic [7:0]   b;

    // Values derived from the state and the current byte.
    always_comb begin
        b           = i_item.data_byte;
        w_pos       = i_state.byte_position + 12'd1;
        w_optoff    = 17'(i_state.hdr_offset) + 17'(i_state.option_start);
        w_remaining = i_state.header_total - i_state.option_start;
        w_len_dec   = i_state.option_length - 8'd1;
        w_jacc      = {i_state.jumbo_acc[23:0], i_item.data_byte};
        w_jsum      = 33'(w_jacc) + BASE_HDR;
        w_plen      = 33'(i_item.packet_length);
        w_is_jumbo  = i_state.hop && (i_state.option_type == OPT_JUMBO);
    end

    // Next state and the decision to give a verdict.
    always_comb begin
        n_st        = i_state;
        w_emit      = 1'b0;
        w_emit_v    = V_ACCEPT;
        w_fail      = 1'b0;
        w_fail_v    = V_DROP;
        w_fail_code = PC_FIELD;
        w_fail_ptr  = '0;
        w_last      = 1'b0;
        if (i_item.first_byte) begin
            // A new header clears everything and latches its context.
            n_st            = '0;
            n_st.phase      = PH_HLEN;
            n_st.hdr_offset = i_item.header_offset;
            n_st.hop        = i_item.hop_by_hop;
            n_st.mcast      = i_item.dest_multicast;
            n_st.plz        = i_item.payload_len_zero;
            if (i_item.end_of_data) begin
                w_emit     = 1'b1;
                w_emit_v   = V_DROP;
                n_st.phase = PH_IDLE;
            end
        end else if (i_state.phase != PH_IDLE) begin
            n_st.byte_position = w_pos;
            unique case (i_state.phase)
                PH_HLEN: begin
                    n_st.header_total = {9'(b) + 9'd1, 3'b000};
                    n_st.phase        = PH_TYPE;
                end
                PH_TYPE: begin
                    n_st.option_start = w_pos;
                    n_st.option_type  = b;
                    if (b != OPT_PAD1) begin
                        n_st.phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_st.option_length = b;
                    if ((13'(b) + 13'd2) > 13'(w_remaining)) begin
                        // Option runs past the end of the header.
                        w_fail = 1'b1;
                    end else if (i_state.option_type != OPT_PADN) begin
                        if (i_state.hop && (i_state.option_type == OPT_RA)) begin
                            if (b != RA_LEN) begin
                                w_fail = 1'b1;
                            end else begin
                                n_st.found[0]     = 1'b1;
                                n_st.alert_offset = w_optoff;
                            end
                        end else if (w_is_jumbo) begin
                            if ((b != JUMBO_LEN) || (w_optoff[1:0] != JUMBO_ALIGN)) begin
                                w_fail = 1'b1;
                            end else begin
                                n_st.jumbo_acc = '0;
                            end
                        end else begin
                            // Unknown option: the top two type bits pick the action.
                            unique case (i_state.option_type[7:6])
                                ACT_SKIP: ;
                                ACT_DROP: w_fail = 1'b1;
                                ACT_PROBLEM: begin
                                    w_fail      = 1'b1;
                                    w_fail_v    = V_PROBLEM;
                                    w_fail_code = PC_OPTION;
                                    w_fail_ptr  = w_optoff;
                                end
                                ACT_PROBLEM_UCAST: begin
                                    w_fail = 1'b1;
                                    if (!i_state.mcast) begin
                                        w_fail_v    = V_PROBLEM;
                                        w_fail_code = PC_OPTION;
                                        w_fail_ptr  = w_optoff;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    if (!w_fail) begin
                        n_st.phase = (b == 8'd0) ? PH_TYPE : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (w_is_jumbo) begin
                        n_st.jumbo_acc = w_jacc;
                    end
                    n_st.option_length = w_len_dec;
                    if (w_len_dec == 8'd0) begin
                        n_st.phase = PH_TYPE;
                        // Jumbo value complete: range, payload length and size checks.
                        if (w_is_jumbo) begin
                            if (w_jacc[31:16] == 16'd0) begin
                                w_fail      = 1'b1;
                                w_fail_v    = V_PROBLEM;
                                w_fail_ptr  = w_optoff + 17'd2;
                            end else if (!i_state.plz) begin
                                w_fail      = 1'b1;
                                w_fail_v    = V_PROBLEM;
                                w_fail_ptr  = w_optoff;
                            end else if (w_jsum > w_plen) begin
                                w_fail = 1'b1;
                            end else begin
                                n_st.found[1] = 1'b1;
                                n_st.found[2] = (w_jsum < w_plen);
                            end
                        end
                    end
                end
                default: ;
            endcase

            // The first error is held; the rest of the header is only counted.
            if (w_fail) begin
                if (i_state.err_verdict == V_ACCEPT) begin
                    n_st.err_verdict = w_fail_v;
                    n_st.err_code    = w_fail_code;
                    n_st.err_pointer = w_fail_ptr;
                end
                n_st.phase = PH_SKIP;
            end

            // Last header byte gives the verdict; a buffer that ends early drops.
            w_last = (n_st.header_total != 12'd0) &&
                     (w_pos == n_st.header_total - 12'd1);
            if (w_last) begin
                w_emit = 1'b1;
                if (n_st.err_verdict != V_ACCEPT) begin
                    w_emit_v = n_st.err_verdict;
                end else if (n_st.phase == PH_TYPE) begin
                    w_emit_v = V_ACCEPT;
                end else begin
                    w_emit_v = V_DROP;
                end
                n_st.phase = PH_IDLE;
            end else if (i_item.end_of_data) begin
                w_emit     = 1'b1;
                w_emit_v   = V_DROP;
                n_st.phase = PH_IDLE;
            end
        end
    end

    // Result fields, masked by the verdict.
    always_comb begin
        w_acc                         = (w_emit_v == V_ACCEPT);
        o_result.verdict              = w_emit_v;
        o_result.problem_code         = (w_emit_v == V_PROBLEM) ? n_st.err_code : PC_FIELD;
        o_result.problem_pointer      = (w_emit_v == V_PROBLEM) ? n_st.err_pointer : '0;
        o_result.router_alert_present = w_acc && n_st.found[0];
        o_result.router_alert_offset  = (w_acc && n_st.found[0]) ? n_st.alert_offset : '0;
        o_result.jumbo_present        = w_acc && n_st.found[1];
        o_result.jumbo_length         = (w_acc && n_st.found[1]) ? n_st.jumbo_acc : '0;
        o_result.trim_needed          = w_acc && n_st.found[1] && n_st.found[2];
        o_result.header_bytes         = n_st.header_total;
    end

    assign o_next_state = n_st;
    assign o_emit       = w_emit;

endmodule

### rtl/core/ipv6_tlv_option_parser_core.sv
// ----------------------------------------------------------------------------
// ipv6_tlv_option_parser_core
// Walks the TLV options of an IPv6 hop-by-hop or destination options header
// and gives at most one verdict per header.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one header byte per item, starting at the
// next-header byte; first_byte marks the start of a header and latches the
// per-header context (mode, offset, multicast, zero payload length).
// The output channel carries at most one verdict item per header, given on the last
// header byte, or on the byte flagged end_of_data if the buffer ends first.
// Bytes that arrive outside a header are ignored and give no item.
// Throughput is one byte per cycle while the output does not stall: each byte
// passes through an input register, the parse logic and a result register.
// A verdict passes the input register and then the result register before
// it appears on the outputs.
// A stalled verdict stays in the result register. The input register can
// take one more byte, and the input then stalls until the receiver takes the
// verdict, since no byte moves on while the result register is held.
// Reset returns the parser to idle, empties both registers and clears all
// held header state.
// ----------------------------------------------------------------------------
module ipv6_tlv_option_parser_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ipv6tlv_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ipv6tlv_pkg::t_out_item o_out_item
);
    import ipv6tlv_pkg::*;

    t_in_item     r_in;
    logic         r_in_valid;
    t_parse_state r_st;
    t_parse_state n_st;
    t_out_item    r_out;
    logic         r_out_valid;
    t_out_item    w_result;
    logic         w_emit;
    logic         w_advance;

    // A byte moves on when the result register is free or being emptied.
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    ipv6tlv_step u_step (
        .i_state      (r_st),
        .i_item       (r_in),
        .o_next_state (n_st),
        .o_emit       (w_emit),
        .o_result     (w_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_advance) begin
            r_st <= n_st;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // A verdict formed by the parse logic lands in the result register.
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit) |=> o_out_valid)
        else $error("verdict formed but result register not loaded");

    // Only an accepted header reports router alert or jumbo information.
    a_accept_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.verdict != V_ACCEPT)) |->
        (!o_out_item.router_alert_present && !o_out_item.jumbo_present &&
         !o_out_item.trim_needed))
        else $error("option flags reported on a dropped header");

    // A trim request always comes with an accepted jumbo option.
    a_trim_jumbo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.trim_needed) |-> o_out_item.jumbo_present)
        else $error("trim flagged without jumbo payload");

    // Problem code and pointer are only set for a parameter problem.
    a_problem_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.verdict != V_PROBLEM)) |->
        ((o_out_item.problem_code == PC_FIELD) && (o_out_item.problem_pointer == '0)))
        else $error("problem fields set without parameter problem verdict");
`endif

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IPv6 extension header TLV option parser. Headers
// are fed one byte per item: directed headers first, then random well-formed
// and broken option sequences under several mixes of sender gaps and output
// stalls. A built-in parser predicts at most one verdict per header, and each verdict
// the block gives is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv6tlv_pkg::*;

    // Smallest jumbo payload length that is not an error.
    localparam logic [31:0] JUMBO_MIN = 32'h0001_0000;

    logic     i_clk;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_item i_in_item   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_item o_out_item;

    ipv6_tlv_option_parser_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Idle and stall mix of the current phase, in percent.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    int bytes_sent    = 0;
    int headers_sent  = 0;
    int verdicts_seen = 0;
    int fail_count    = 0;
    int verdict_count [3] = '{0, 0, 0};

    t_in_item  hdr_q[$];       // bytes of the header being built
    t_out_item verdict_q[$];   // predicted verdicts not yet seen
    t_out_item want;

    // Predicted parser state.
    t_phase      ph = PH_IDLE;
    logic [11:0] hdr_total;
    logic [11:0] byte_pos;
    logic [11:0] opt_start;
    logic [7:0]  opt_type;
    logic [7:0]  opt_len;
    logic [31:0] jumbo_val;
    logic [15:0] ctx_off;
    logic        ctx_hop;
    logic        ctx_mcast;
    logic        ctx_plz;
    logic [2:0]  found;        // bit 0 router alert, bit 1 jumbo, bit 2 trim
    logic [16:0] alert_off;
    logic [1:0]  err_v;
    logic        err_c;
    logic [16:0] err_p;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random output stalls.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Header parse prediction
    // ------------------------------------------------------------------------

    // The first error of a header is kept; the rest of the header is counted.
    function automatic void note_fail(input logic [1:0] v, input logic c,
                                      input logic [16:0] p);
        if (err_v == V_ACCEPT) begin
            err_v = v;
            err_c = c;
            err_p = p;
        end
        ph = PH_SKIP;
    endfunction

    function automatic void post_verdict(input logic [1:0] v);
        t_out_item r;
        logic      acc;
        acc                    = (v == V_ACCEPT);
        r.verdict              = v;
        r.problem_code         = (v == V_PROBLEM) ? err_c : PC_FIELD;
        r.problem_pointer      = (v == V_PROBLEM) ? err_p : 17'd0;
        r.router_alert_present = acc & found[0];
        r.router_alert_offset  = (acc && found[0]) ? alert_off : 17'd0;
        r.jumbo_present        = acc & found[1];
        r.jumbo_length         = (acc && found[1]) ? jumbo_val : 32'd0;
        r.trim_needed          = (acc && found[1]) ? found[2] : 1'b0;
        r.header_bytes         = hdr_total;
        verdict_q.push_back(r);
        ph = PH_IDLE;
    endfunction

    function automatic void predict_byte(input t_in_item it);
        logic [7:0]  b;
        logic [16:0] optoff;
        logic [32:0] need;
        logic        is_jumbo;
        t_phase      nxt;
        b = it.data_byte;
        // A first byte always opens a new header and latches its context.
        if (it.first_byte) begin
            hdr_total = '0;
            byte_pos  = '0;
            opt_start = '0;
            opt_type  = '0;
            opt_len   = '0;
            jumbo_val = '0;
            found     = '0;
            alert_off = '0;
            err_v     = V_ACCEPT;
            err_c     = PC_FIELD;
            err_p     = '0;
            ctx_off   = it.header_offset;
            ctx_hop   = it.hop_by_hop;
            ctx_mcast = it.dest_multicast;
            ctx_plz   = it.payload_len_zero;
            ph        = PH_HLEN;
            if (it.end_of_data) post_verdict(V_DROP);
            return;
        end
        if (ph == PH_IDLE) return;

        byte_pos = byte_pos + 12'd1;
        optoff   = 17'(ctx_off) + 17'(opt_start);
        nxt      = (b == 8'd0) ? PH_TYPE : PH_BODY;
        is_jumbo = ctx_hop && (opt_type == OPT_JUMBO);
        case (ph)
            PH_HLEN: begin
                hdr_total = 12'((int'(b) + 1) * 8);
                ph = PH_TYPE;
            end
            PH_TYPE: begin
                opt_start = byte_pos;
                opt_type  = b;
                if (b != OPT_PAD1) ph = PH_LEN;
            end
            PH_LEN: begin
                opt_len = b;
                if (int'(b) + 2 > int'(hdr_total) - int'(opt_start)) begin
                    note_fail(V_DROP, PC_FIELD, '0);
                end else if (opt_type == OPT_PADN) begin
                    ph = nxt;
                end else if (ctx_hop && opt_type == OPT_RA) begin
                    if (b != RA_LEN) begin
                        note_fail(V_DROP, PC_FIELD, '0);
                    end else begin
                        found[0]  = 1'b1;
                        alert_off = optoff;
                        ph = nxt;
                    end
                end else if (is_jumbo) begin
                    if (b != JUMBO_LEN || optoff[1:0] != JUMBO_ALIGN) begin
                        note_fail(V_DROP, PC_FIELD, '0);
                    end else begin
                        jumbo_val = '0;
                        ph = nxt;
                    end
                end else begin
                    // Unknown option: the top two type bits pick the action.
                    case (opt_type[7:6])
                        ACT_SKIP:    ph = nxt;
                        ACT_DROP:    note_fail(V_DROP, PC_FIELD, '0);
                        ACT_PROBLEM: note_fail(V_PROBLEM, PC_OPTION, optoff);
                        ACT_PROBLEM_UCAST: begin
                            if (ctx_mcast) note_fail(V_DROP, PC_FIELD, '0);
                            else note_fail(V_PROBLEM, PC_OPTION, optoff);
                        end
                    endcase
                end
            end
            PH_BODY: begin
                if (is_jumbo) jumbo_val = {jumbo_val[23:0], b};
                opt_len = opt_len - 8'd1;
                if (opt_len == 8'd0) begin
                    ph = PH_TYPE;
                    // The last jumbo byte brings the packet length to check against.
                    if (is_jumbo) begin
                        need = {1'b0, jumbo_val} + BASE_HDR;
                        if (jumbo_val < JUMBO_MIN) begin
                            note_fail(V_PROBLEM, PC_FIELD, optoff + 17'd2);
                        end else if (!ctx_plz) begin
                            note_fail(V_PROBLEM, PC_FIELD, optoff);
                        end else if (need > {1'b0, it.packet_length}) begin
                            note_fail(V_DROP, PC_FIELD, '0);
                        end else begin
                            found[1] = 1'b1;
                            found[2] = (need < {1'b0, it.packet_length});
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // The last header byte gives the verdict; an early buffer end drops.
        if (hdr_total != 12'd0 && byte_pos == hdr_total - 12'd1) begin
            if (err_v != V_ACCEPT) post_verdict(err_v);
            else if (ph == PH_TYPE) post_verdict(V_ACCEPT);
            else post_verdict(V_DROP);
        end else if (it.end_of_data) begin
            post_verdict(V_DROP);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Verdict checking
    // ------------------------------------------------------------------------

    function automatic void cmp(input string fname, input logic [31:0] exp_val,
                                input logic [31:0] got);
        if (got !== exp_val) begin
            $error("%s: expected %0h, got %0h", fname, exp_val, got);
            fail_count++;
        end
    endfunction

    // Each accepted verdict is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("verdict with none predicted: %h", o_out_item);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                cmp("verdict", 32'(want.verdict), 32'(o_out_item.verdict));
                cmp("problem_code", 32'(want.problem_code),
                    32'(o_out_item.problem_code));
                cmp("problem_pointer", 32'(want.problem_pointer),
                    32'(o_out_item.problem_pointer));
                cmp("router_alert_present", 32'(want.router_alert_present),
                    32'(o_out_item.router_alert_present));
                cmp("router_alert_offset", 32'(want.router_alert_offset),
                    32'(o_out_item.router_alert_offset));
                cmp("jumbo_present", 32'(want.jumbo_present),
                    32'(o_out_item.jumbo_present));
                cmp("jumbo_length", want.jumbo_length, o_out_item.jumbo_length);
                cmp("trim_needed", 32'(want.trim_needed),
                    32'(o_out_item.trim_needed));
                cmp("header_bytes", 32'(want.header_bytes),
                    32'(o_out_item.header_bytes));
                verdicts_seen++;
                verdict_count[want.verdict]++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte and header building and sending
    // ------------------------------------------------------------------------

    // A byte with random per-byte context, which the parser must ignore.
    function automatic t_in_item noise_item(input logic [7:0] b);
        t_in_item it;
        it.data_byte        = b;
        it.first_byte       = 1'b0;
        it.end_of_data      = 1'b0;
        it.hop_by_hop       = 1'($urandom);
        it.header_offset    = 16'($urandom);
        it.dest_multicast   = 1'($urandom);
        it.payload_len_zero = 1'($urandom);
        it.packet_length    = $urandom;
        return it;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        hdr_q.push_back(noise_item(b));
    endfunction

    // Pads n bytes with Pad1 and PadN options.
    function automatic void fill_pad(input int n);
        int k;
        while (n > 0) begin
            if (n == 1) begin
                add_byte(OPT_PAD1);
                n = 0;
            end else begin
                k = (n > 257) ? 257 : n;
                if (n - k == 1) k--;
                add_byte(OPT_PADN);
                add_byte(8'(k - 2));
                repeat (k - 2) add_byte(8'($urandom));
                n -= k;
            end
        end
    endfunction

    // An option that does not fit is mostly replaced by padding, else overruns.
    function automatic void put_option(input logic [7:0] t, input int len,
                                       input int total);
        int room;
        room = total - hdr_q.size();
        if (len + 2 > room && $urandom_range(9) != 0) begin
            fill_pad(room);
        end else begin
            add_byte(t);
            add_byte(8'(len));
            repeat (len) add_byte(8'($urandom));
        end
    endfunction

    // Shortest header: next header, length 0 and six option bytes.
    function automatic void hdr8(input logic [47:0] body);
        add_byte(8'($urandom));
        add_byte(8'h00);
        for (int i = 5; i >= 0; i--) add_byte(body[i*8 +: 8]);
    endfunction

    task automatic send_byte(input t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_byte(it);
        bytes_sent++;
    endtask

    // Sends the built header; eod_idx < 0 means no early end, keep <= 0 all bytes.
    task automatic send_header(input logic hop, input logic [15:0] off,
                               input logic mcast, input logic plz,
                               input int eod_idx, input int keep);
        int n;
        hdr_q[0].first_byte       = 1'b1;
        hdr_q[0].hop_by_hop       = hop;
        hdr_q[0].header_offset    = off;
        hdr_q[0].dest_multicast   = mcast;
        hdr_q[0].payload_len_zero = plz;
        if (eod_idx >= 0) hdr_q[eod_idx].end_of_data = 1'b1;
        n = (keep > 0) ? keep : hdr_q.size();
        for (int i = 0; i < n; i++) send_byte(hdr_q[i]);
        hdr_q.delete();
        headers_sent++;
    endtask

    task automatic send_stray(input int n);
        repeat (n) send_byte(noise_item(8'($urandom)));
    endtask

    // Holds the input until every predicted verdict is back, plus the latency.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_padding();
        hdr8(48'h00_00_00_00_00_00);
        send_header(1'b1, 16'h0000, 1'b0, 1'b1, -1, 0);
        hdr8(48'h01_04_FF_FF_FF_FF);
        send_header(1'b0, 16'hFFFF, 1'b1, 1'b0, -1, 0);
        hdr8(48'h00_01_00_01_02_AA);
        send_header(1'b1, 16'h1234, 1'b0, 1'b1, -1, 0);
    endtask

    task automatic test_router_alert();
        // Valid alert at the highest header offset.
        hdr8(48'h05_02_00_00_01_00);
        send_header(1'b1, 16'hFFFF, 1'b0, 1'b1, -1, 0);
        // Wrong length.
        hdr8(48'h05_03_00_00_00_00);
        send_header(1'b1, 16'h0040, 1'b0, 1'b1, -1, 0);
        // Type 5 is an unknown skip option in destination mode.
        hdr8(48'h05_02_00_00_01_00);
        send_header(1'b0, 16'h0040, 1'b0, 1'b1, -1, 0);
    endtask

    task automatic test_jumbo();
        // Accepted with trim, then exactly fitting.
        hdr8(48'hC2_04_00_01_23_45);
        hdr_q[7].packet_length = 32'h0001_2345 + 32'd41;
        send_header(1'b1, 16'h0000, 1'b0, 1'b1, -1, 0);
        hdr8(48'hC2_04_FF_FF_FF_D7);
        hdr_q[7].packet_length = 32'hFFFF_FFFF;
        send_header(1'b1, 16'hFFFC, 1'b0, 1'b1, -1, 0);
        // Value too small for a jumbo.
        hdr8(48'hC2_04_00_00_FF_FF);
        send_header(1'b1, 16'h0000, 1'b0, 1'b1, -1, 0);
        // Base payload length not zero.
        hdr8(48'hC2_04_00_02_00_00);
        hdr_q[7].packet_length = 32'h0002_0028;
        send_header(1'b1, 16'h0000, 1'b0, 1'b0, -1, 0);
        // Longer than the packet.
        hdr8(48'hC2_04_FF_FF_FF_FF);
        hdr_q[7].packet_length = 32'hFFFF_FFFF;
        send_header(1'b1, 16'h0000, 1'b0, 1'b1, -1, 0);
        // Misaligned, then wrong length.
        hdr8(48'hC2_04_00_02_00_00);
        send_header(1'b1, 16'h0001, 1'b0, 1'b1, -1, 0);
        hdr8(48'hC2_03_00_02_00_00);
        send_header(1'b1, 16'h0000, 1'b0, 1'b1, -1, 0);
        // In destination mode the jumbo type is an unknown option.
        hdr8(48'hC2_04_00_02_00_00);
        send_header(1'b0, 16'h0000, 1'b1, 1'b1, -1, 0);
        hdr8(48'hC2_04_00_02_00_00);
        send_header(1'b0, 16'h0000, 1'b0, 1'b1, -1, 0);
    endtask

    task automatic test_unknown_actions();
        hdr8(48'h1E_04_11_22_33_44);
        send_header(1'b1, 16'h0100, 1'b0, 1'b1, -1, 0);
        hdr8(48'h5E_00_00_00_00_00);
        send_header(1'b1, 16'h0100, 1'b0, 1'b1, -1, 0);
        hdr8(48'h9E_00_00_00_00_00);
        send_header(1'b1, 16'h0100, 1'b1, 1'b1, -1, 0);
        hdr8(48'hDE_00_00_00_00_00);
        send_header(1'b0, 16'h0100, 1'b1, 1'b1, -1, 0);
        hdr8(48'hDE_00_00_00_00_00);
        send_header(1'b0, 16'h0100, 1'b0, 1'b1, -1, 0);
    endtask

    task automatic test_malformed();
        // PadN running past the header end.
        hdr8(48'h01_05_00_00_00_00);
        send_header(1'b1, 16'h0008, 1'b0, 1'b1, -1, 0);
        // An option type on the last header byte.
        hdr8(48'h01_03_00_00_00_05);
        send_header(1'b1, 16'h0008, 1'b0, 1'b1, -1, 0);
        // The first error is kept over later ones.
        hdr8(48'h9E_00_DE_00_01_00);
        send_header(1'b0, 16'h0008, 1'b1, 1'b1, -1, 0);
        hdr8(48'h5E_00_9E_00_01_00);
        send_header(1'b1, 16'h0008, 1'b0, 1'b1, -1, 0);
    endtask

    task automatic test_truncation();
        // Buffer ends inside a good header, and after a held error.
        hdr8(48'h01_04_00_00_00_00);
        send_header(1'b1, 16'h0020, 1'b0, 1'b1, 4, 0);
        hdr8(48'h9E_00_01_02_00_00);
        send_header(1'b1, 16'h0020, 1'b0, 1'b1, 5, 0);
        // Buffer ends on the first byte.
        hdr8(48'h01_04_00_00_00_00);
        send_header(1'b1, 16'h0020, 1'b0, 1'b1, 0, 1);
        // Buffer ends exactly on the last header byte.
        hdr8(48'h01_04_00_00_00_00);
        send_header(1'b1, 16'h0020, 1'b0, 1'b1, 7, 0);
    endtask

    task automatic test_framing();
        // Bytes outside any header.
        send_stray(3);
        // A new header in the middle of one drops the old header.
        hdr8(48'h5E_00_00_00_00_00);
        send_header(1'b1, 16'h0030, 1'b0, 1'b1, -1, 5);
        hdr8(48'h9E_00_00_00_00_00);
        send_header(1'b1, 16'h0030, 1'b0, 1'b1, -1, 0);
    endtask

    task automatic test_largest_header();
        // Longest header length, cut short by the buffer end after a held
        // error whose pointer is past 16 bits.
        add_byte(8'($urandom));
        add_byte(8'hFF);
        fill_pad(40);
        add_byte(8'h9E);
        add_byte(8'h00);
        send_header(1'b1, 16'hFFFF, 1'b0, 1'b1, hdr_q.size() - 1, 0);
    endtask

    task automatic send_random_header();
        logic        hop;
        logic        mcast;
        logic        plz;
        logic [15:0] off;
        logic [31:0] v;
        logic [31:0] plen;
        int          hl;
        int          total;
        int          r;
        int          eod_idx;
        int          keep;
        hop   = ($urandom_range(99) < 70);
        mcast = 1'($urandom);
        plz   = ($urandom_range(99) < 75);
        off   = ($urandom_range(19) == 0) ? 16'hFFFF : 16'($urandom);
        r     = $urandom_range(99);
        hl    = (r < 85) ? $urandom_range(0, 3) :
                (r < 97) ? $urandom_range(4, 15) : $urandom_range(16, 40);
        total = (hl + 1) * 8;
        add_byte(8'($urandom));
        add_byte(8'(hl));

        // Fill the option area with a mix of options, mostly well formed.
        while (hdr_q.size() < total) begin
            r = $urandom_range(99);
            if (r < 10) begin
                add_byte(OPT_PAD1);
            end else if (r < 25) begin
                put_option(OPT_PADN, $urandom_range(0, 8), total);
            end else if (r < 45) begin
                put_option(OPT_RA, ($urandom_range(9) != 0) ? 2 : $urandom_range(0, 6),
                           total);
            end else if (r < 65) begin
                if ($urandom_range(9) != 0) begin
                    while (2'(off + 16'(hdr_q.size())) != JUMBO_ALIGN &&
                           hdr_q.size() < total)
                        add_byte(OPT_PAD1);
                end
                if (total - hdr_q.size() >= 6 && $urandom_range(9) != 0) begin
                    v = ($urandom_range(99) < 20) ? $urandom_range(0, 65535) :
                        $urandom_range(32'h0001_0000, 32'hFFFF_FF00);
                    r = $urandom_range(99);
                    if (r < 35) plen = v + 32'd40;
                    else if (r < 70) plen = v + 32'd40 + $urandom_range(1, 5000);
                    else if (r < 85) plen = v + 32'd40 - $urandom_range(1, 100);
                    else plen = $urandom;
                    add_byte(OPT_JUMBO);
                    add_byte(JUMBO_LEN);
                    for (int i = 3; i >= 0; i--) add_byte(v[i*8 +: 8]);
                    hdr_q[hdr_q.size() - 1].packet_length = plen;
                end else begin
                    put_option(OPT_JUMBO, $urandom_range(0, 6), total);
                end
            end else if (r < 92) begin
                put_option(8'($urandom), $urandom_range(0, 6), total);
            end else begin
                add_byte(8'($urandom));
            end
        end
        while (hdr_q.size() > total) void'(hdr_q.pop_back());

        // Some headers end early, are cut by a restart, or end on the first byte.
        eod_idx = -1;
        keep    = 0;
        r = $urandom_range(99);
        if (r < 7) eod_idx = $urandom_range(1, total - 1);
        else if (r < 12) keep = $urandom_range(1, total - 1);
        else if (r < 15) eod_idx = 0;
        else if (r < 20) eod_idx = total - 1;
        send_header(hop, off, mcast, plz, eod_idx, keep);
        if ($urandom_range(99) < 6) send_stray($urandom_range(1, 3));
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int n_bytes);
        int b0;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        b0 = bytes_sent;
        while (bytes_sent - b0 < n_bytes)
            send_random_header();
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_padding();
        test_router_alert();
        test_jumbo();
        test_unknown_actions();
        test_malformed();
        test_truncation();
        test_framing();
        test_largest_header();
        wait_drained();

        test_random(0, 0, 205);
        test_random(57, 0, 205);
        test_random(0, 57, 205);
        test_random(31, 31, 205);

        $display("Sent %0d bytes in %0d headers; checked %0d verdicts:",
                 bytes_sent, headers_sent, verdicts_seen);
        $display("%0d accept, %0d drop, %0d problem, over padding, router alert, %s",
                 verdict_count[V_ACCEPT], verdict_count[V_DROP],
                 verdict_count[V_PROBLEM],
                 "jumbo checks, unknown actions, truncation and restarts.");
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ipv6tlv_pkg.sv
rtl/core/ipv6tlv_step.sv
rtl/core/ipv6_tlv_option_parser_core.sv
tb/tb.sv
